[hdl/swm_pkg.sv]
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// Sample and result formats, register reset value, controller command bundle.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int RESULT_W   = 33;
  localparam int CFG_W      = 5;
  localparam int CFG_RESET  = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [RESULT_W-1:0] result_t;
  typedef logic        [CFG_W-1:0]    win_cfg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic latch_in;   // capture the incoming sample
    logic ring_rd;    // read the oldest sample from the arrival ring
    logic ring_wr;    // write the held sample into the arrival ring
    logic remove;     // drop the oldest sample from the sorted row
    logic insert;     // place the held sample into the sorted row
    logic load_out;   // load the output register with twice the median
  } swm_cmd_t;

endpackage

[hdl/swm_ram.sv]
// ----------------------------------------------------------------------------
// swm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module swm_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/swm_datapath.sv]
// ----------------------------------------------------------------------------
// swm_datapath: sample storage and sorted row of the median filter
// Holds the arrival ring (RAM), the sorted row of compare-and-shift cells,
// and the output register carrying twice the median.
// ----------------------------------------------------------------------------
module swm_datapath #(
  parameter int MAX_WINDOW = 16,
  parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  parameter int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                clk,
  input  swm_pkg::swm_cmd_t   cmd,
  input  swm_pkg::sample_t    sample,
  input  logic [IDX_W-1:0]    ring_slot,
  input  logic [LEN_W-1:0]    ins_count,
  input  logic [IDX_W-1:0]    lo_idx,
  input  logic [IDX_W-1:0]    hi_idx,
  output swm_pkg::result_t    median_twice
);
  import swm_pkg::*;

  sample_t sample_q;
  sample_t oldest;
  sample_t sorted      [MAX_WINDOW];
  sample_t sorted_next [MAX_WINDOW];
  logic    [MAX_WINDOW-1:0] ge_old;
  logic    [MAX_WINDOW-1:0] gt_new;

  // hold the accepted sample for the rest of the item
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      sample_q <= sample;
    end
  end

  // arrival ring: slot of the oldest sample is read, then overwritten
  swm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (MAX_WINDOW),
    .ADDR_W(IDX_W)
  ) u_ring (
    .clk    (clk),
    .wr_en  (cmd.ring_wr),
    .wr_addr(ring_slot),
    .wr_data(sample_q),
    .rd_en  (cmd.ring_rd),
    .rd_addr(ring_slot),
    .rd_data(oldest)
  );

  // per-cell compares; both predicates are monotonic over the sorted row
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      ge_old[i] = (sorted[i] >= oldest);
      gt_new[i] = (LEN_W'(i) >= ins_count) || (sorted[i] > sample_q);
    end
  end

  // remove: cells at or above the oldest value take their upper neighbor
  // insert: cells above the new value take their lower neighbor or the sample
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sorted_next[i] = sorted[i];
      if (cmd.remove) begin
        if (ge_old[i] && (i < MAX_WINDOW - 1)) begin
          sorted_next[i] = sorted[(i < MAX_WINDOW - 1) ? i + 1 : i];
        end
      end else if (cmd.insert) begin
        if (gt_new[i]) begin
          if (i == 0) begin
            sorted_next[i] = sample_q;
          end else if (!gt_new[(i > 0) ? i - 1 : 0]) begin
            sorted_next[i] = sample_q;
          end else begin
            sorted_next[i] = sorted[(i > 0) ? i - 1 : 0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sorted[i] <= sorted_next[i];
    end
  end

  // sum of the two middle cells; equal indices for an odd window
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      median_twice <= RESULT_W'(sorted[lo_idx]) + RESULT_W'(sorted[hi_idx]);
    end
  end

endmodule

[hdl/swm_ctrl.sv]
// ----------------------------------------------------------------------------
// swm_ctrl: controller of the median filter
// Tracks window length, fill count and oldest slot, sequences the datapath
// and owns both handshakes.
// ----------------------------------------------------------------------------
module swm_ctrl #(
  parameter int MAX_WINDOW = 16,
  parameter int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  parameter int LEN_W      = $clog2(MAX_WINDOW + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  swm_pkg::win_cfg_t    cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output swm_pkg::swm_cmd_t    cmd,
  output logic [IDX_W-1:0]     ring_slot,
  output logic [LEN_W-1:0]     ins_count,
  output logic [IDX_W-1:0]     lo_idx,
  output logic [IDX_W-1:0]     hi_idx
);
  import swm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_REMOVE,
    S_INSERT,
    S_EMIT
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  eff_len;
  logic [LEN_W-1:0]  fill_count;
  logic [IDX_W-1:0]  oldest_ptr;
  logic              emit_pend;
  logic [LEN_W-1:0]  fill_start;
  logic [LEN_W-1:0]  slot_inc;
  logic              accept;
  logic              out_free;

  // clamp the programmed length into 1..MAX_WINDOW
  function automatic logic [LEN_W-1:0] clamp_len(input win_cfg_t wl);
    logic [LEN_W-1:0] r;
    if (wl == '0) begin
      r = LEN_W'(1);
    end else if (int'(wl) > MAX_WINDOW) begin
      r = LEN_W'(MAX_WINDOW);
    end else begin
      r = LEN_W'(wl);
    end
    return r;
  endfunction

  assign in_ready   = (state == S_IDLE);
  assign accept     = in_valid && in_ready;
  assign out_free   = !out_valid || out_ready;
  assign fill_start = restart ? '0 : fill_count;
  assign slot_inc   = LEN_W'(ring_slot) + LEN_W'(1);
  assign lo_idx     = IDX_W'((eff_len - LEN_W'(1)) >> 1);
  assign hi_idx     = IDX_W'(eff_len >> 1);

  // decode datapath commands from the state
  always_comb begin
    cmd          = '0;
    cmd.latch_in = accept;
    cmd.ring_rd  = (state == S_READ);
    cmd.remove   = (state == S_REMOVE);
    cmd.insert   = (state == S_INSERT);
    cmd.ring_wr  = (state == S_INSERT);
    cmd.load_out = (state == S_EMIT) && out_free;
  end

  // sequencer, window bookkeeping and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      eff_len    <= clamp_len(win_cfg_t'(CFG_RESET));
      fill_count <= '0;
      oldest_ptr <= '0;
      ring_slot  <= '0;
      ins_count  <= '0;
      emit_pend  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // raise the result on a load, drop it once the receiver takes it
      out_valid <= cmd.load_out || (out_valid && !out_ready);

      // a length write empties the window
      if (cfg_wr_en) begin
        eff_len    <= clamp_len(cfg_wr_data);
        fill_count <= '0;
        oldest_ptr <= '0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (restart || (fill_count < eff_len)) begin
              // filling: append at the next free slot
              ring_slot  <= IDX_W'(fill_start);
              ins_count  <= fill_start;
              fill_count <= fill_start + LEN_W'(1);
              oldest_ptr <= '0;
              emit_pend  <= ((fill_start + LEN_W'(1)) == eff_len);
              state      <= S_INSERT;
            end else begin
              // full: replace the oldest sample
              ring_slot <= oldest_ptr;
              ins_count <= eff_len - LEN_W'(1);
              emit_pend <= 1'b1;
              state     <= S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_REMOVE;
        end
        S_REMOVE: begin
          state <= S_INSERT;
        end
        S_INSERT: begin
          // advance the oldest slot after a replacement, wrapping at the length
          if (fill_count == eff_len && ring_slot == oldest_ptr) begin
            oldest_ptr <= (slot_inc == eff_len) ? '0 : IDX_W'(slot_inc);
          end
          state <= emit_pend ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/sliding_window_median_top.sv]
// ----------------------------------------------------------------------------
// sliding_window_median_top: running median filter over a signed stream
// Keeps the last window_len samples in arrival order and in sorted order and
// reports twice the median once the window is full.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one beat per sample with a
//   restart flag that empties the window before the sample is taken.
//   Output channel out_valid/out_ready carries median_twice: the sum of the
//   two middle samples for an even window, double the middle one otherwise.
//   cfg_wr_en/cfg_wr_data write window_len (0 acts as 1, above MAX_WINDOW as
//   MAX_WINDOW) and empty the window; write only while the block is idle.
//   While the window fills, a sample is inserted into the sorted row and the
//   ring; the sample that fills it then loads the output. Once full, a sample
//   steps through ring read, remove from the sorted row, insert, output load
//   and the return to idle; the next sample is taken only back in idle. The
//   single ring RAM port pair and the remove-then-insert pass over the sorted
//   cells set these steps.
//   Reset empties the window, sets window_len to 3 and drops out_valid.
//   A stalled receiver holds the result in the output register; the next
//   sample is still taken and waits only when its own result is due.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  swm_pkg::win_cfg_t   cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  swm_pkg::sample_t    sample,
  input  logic                restart,
  output logic                out_valid,
  input  logic                out_ready,
  output swm_pkg::result_t    median_twice
);
  import swm_pkg::*;

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int LEN_W = $clog2(MAX_WINDOW + 1);

  swm_cmd_t          cmd;
  logic [IDX_W-1:0]  ring_slot;
  logic [LEN_W-1:0]  ins_count;
  logic [IDX_W-1:0]  lo_idx;
  logic [IDX_W-1:0]  hi_idx;

  swm_ctrl #(
    .MAX_WINDOW(MAX_WINDOW),
    .IDX_W     (IDX_W),
    .LEN_W     (LEN_W)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .restart    (restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .ring_slot  (ring_slot),
    .ins_count  (ins_count),
    .lo_idx     (lo_idx),
    .hi_idx     (hi_idx)
  );

  swm_datapath #(
    .MAX_WINDOW(MAX_WINDOW),
    .IDX_W     (IDX_W),
    .LEN_W     (LEN_W)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sample      (sample),
    .ring_slot   (ring_slot),
    .ins_count   (ins_count),
    .lo_idx      (lo_idx),
    .hi_idx      (hi_idx),
    .median_twice(median_twice)
  );

endmodule

[hdl/swm_checker.sv]
// ----------------------------------------------------------------------------
// swm_checker: port-level checks of the median filter
// Watches both handshakes and the result timing seen at the top level.
// ----------------------------------------------------------------------------
module swm_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input swm_pkg::result_t median_twice
);
  import swm_pkg::*;

  // hold a stalled result beat
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(median_twice))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // one sample at a time: no beat in the cycle after a beat
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a sample is in work");

  // a fresh result follows a sample beat, after a fill or a replacement
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 3) || $past(in_valid && in_ready, 5))
    else $error("result without a matching sample beat");

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .median_twice(median_twice)
);

[sim/sliding_window_median_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sliding_window_median_top_tb: self-checking bench for the running median filter
// Streams corner-case and random samples through many window lengths, predicts
// twice the median of each full window and checks each output beat in order,
// with random idling on both channels and one stretch without any.
// ----------------------------------------------------------------------------
module sliding_window_median_top_tb;
  import swm_pkg::*;

  localparam int      WIN_MAX        = 16;
  localparam int      IDLE_PCT       = 34;
  localparam int      SETTLE_CYCLES  = 10;
  localparam int      WATCHDOG_LIMIT = 2000;
  localparam sample_t SAMPLE_MAX     = 32'h7fff_ffff;
  localparam sample_t SAMPLE_MIN     = 32'h8000_0000;

  logic     clk         = 1'b0;
  logic     rst         = 1'b1;
  logic     cfg_wr_en   = 1'b0;
  win_cfg_t cfg_wr_data = '0;
  logic     in_valid    = 1'b0;
  logic     in_ready;
  sample_t  sample      = '0;
  logic     restart     = 1'b0;
  logic     out_valid;
  logic     out_ready   = 1'b0;
  result_t  median_twice;

  // Predicted window: arrival order, sorted order, fill level and ring pointer
  sample_t     arrival_q [WIN_MAX];
  sample_t     sorted_q [WIN_MAX];
  int unsigned fill_cnt   = 0;
  int unsigned oldest_ptr = 0;
  win_cfg_t    win_len    = win_cfg_t'(CFG_RESET);

  result_t median_exp_q [$];
  int      fail_count     = 0;
  bit      sender_idles   = 1'b1;
  bit      receiver_idles = 1'b1;

  sliding_window_median_top #(
    .MAX_WINDOW(WIN_MAX)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .restart     (restart),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .median_twice(median_twice)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Insert v into the first n sorted entries, keeping ascending order
  function automatic void sorted_put(input sample_t v, input int unsigned n);
    int unsigned j;
    j = n;
    while (j > 0 && sorted_q[j-1] > v) begin
      sorted_q[j] = sorted_q[j-1];
      j--;
    end
    sorted_q[j] = v;
  endfunction

  // Advance the predicted window by one sample; return 1 with twice the median
  // when the beat yields an output
  function automatic bit slide_window(input sample_t s, input logic rs,
                                      output result_t med);
    int unsigned span;
    int unsigned p;
    int unsigned j;
    int unsigned mid;
    sample_t     leaving;
    med  = '0;
    span = (win_len == 0) ? 1 : (int'(win_len) > WIN_MAX) ? WIN_MAX : int'(win_len);
    if (rs) begin
      fill_cnt   = 0;
      oldest_ptr = 0;
    end
    if (fill_cnt < span) begin
      arrival_q[fill_cnt] = s;
      sorted_put(s, fill_cnt);
      fill_cnt++;
      oldest_ptr = 0;
      if (fill_cnt < span) return 1'b0;
    end else begin
      p       = oldest_ptr % span;
      leaving = arrival_q[p];
      // drop the first sorted copy of the leaving sample
      j = 0;
      while (j < span && sorted_q[j] != leaving) j++;
      while (j + 1 < span) begin
        sorted_q[j] = sorted_q[j+1];
        j++;
      end
      sorted_put(s, span - 1);
      arrival_q[p] = s;
      oldest_ptr   = (p + 1) % span;
    end
    mid = span / 2;
    if (span % 2 == 1)
      med = {sorted_q[mid][31], sorted_q[mid]} + {sorted_q[mid][31], sorted_q[mid]};
    else
      med = {sorted_q[mid-1][31], sorted_q[mid-1]} + {sorted_q[mid][31], sorted_q[mid]};
    return 1'b1;
  endfunction

  // Mix extremes, a narrow band that forces duplicates, and full-range values
  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'($urandom_range(8)) - 4;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Send one beat, optionally after a random gap, and record its prediction
  task automatic send_sample(input sample_t s, input logic rs);
    result_t med;
    if (sender_idles && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= s;
    restart  <= rs;
    do @(posedge clk); while (!in_ready);
    if (slide_window(s, rs, med)) median_exp_q.insert(median_exp_q.size(), med);
  endtask

  // Hold the input side until every predicted beat is out, then let the
  // pipeline settle in case the last sample was still filling
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (median_exp_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write window_len while idle; the write also empties the window
  task automatic set_window(input win_cfg_t len);
    wait_results_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= len;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    win_len    = len;
    fill_cnt   = 0;
    oldest_ptr = 0;
  endtask

  // Reset window of 3: extremes, restart and equal samples
  task automatic test_reset_window();
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(5, 1'b1);
    send_sample(5, 1'b0);
    send_sample(5, 1'b0);
    send_sample(-7, 1'b0);
    wait_results_drained();
  endtask

  // Zero length acting as one, a write that drops a partial fill, even window
  task automatic test_window_edges();
    set_window(5'd0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(0, 1'b1);
    set_window(5'd4);
    send_sample(1, 1'b0);
    send_sample(2, 1'b0);
    set_window(5'd2);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(-3, 1'b1);
    send_sample(3, 1'b0);
    wait_results_drained();
  endtask

  // Random streams over a sweep of lengths, oversized ones included
  task automatic test_random_windows();
    win_cfg_t lens [12] = '{5'd16, 5'd31, 5'd1, 5'd17, 5'd6, 5'd2,
                            5'd11, 5'd0, 5'd15, 5'd4, 5'd9, 5'd3};
    foreach (lens[k]) begin
      set_window(lens[k]);
      for (int i = 0; i < 110; i++) begin
        // pause the stream once per phase until the output side catches up
        if (i == 55) wait_results_drained();
        send_sample(pick_sample(), $urandom_range(99) < 3);
      end
    end
    wait_results_drained();
  endtask

  // Full-rate stretch: no gaps on either side
  task automatic test_back_to_back();
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    set_window(win_cfg_t'($urandom_range(1, WIN_MAX)));
    for (int i = 0; i < 220; i++)
      send_sample(pick_sample(), $urandom_range(99) < 2);
    wait_results_drained();
    sender_idles   = 1'b1;
    receiver_idles = 1'b1;
  endtask

  // Check each output beat against the oldest prediction; drive out_ready
  always @(posedge clk) begin : check_medians
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (median_exp_q.size() == 0) begin
          $error("median_twice: no beat expected, got %0d", median_twice);
          fail_count++;
        end else begin
          want = median_exp_q.pop_front();
          if (median_twice !== want) begin
            $error("median_twice: expected %0d, got %0d", want, median_twice);
            fail_count++;
          end
        end
      end
      out_ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Abort when neither channel nor the register port moves for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_reset_window();
    test_window_edges();
    test_random_windows();
    test_back_to_back();
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
